// ===== sv/bus_slot_discovery_sweep_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bus slot discovery sweep
// Implication checks in the same cycle and in the next cycle.
// ----------------------------------------------------------------------------
`ifndef BUS_SLOT_DISCOVERY_SWEEP_DEFINES_SVH
`define BUS_SLOT_DISCOVERY_SWEEP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define BSDS_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

`define BSDS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`else

`define BSDS_ASSERT_IMPL(label, clk, rst, cond, prop, msg)

`define BSDS_ASSERT_NEXT(label, clk, rst, cond, prop, msg)

`endif

`endif

// ===== sv/bsds_pkg.sv =====
// ----------------------------------------------------------------------------
// bsds_pkg
// Types and codes shared by the discovery sweep modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsds_pkg;

   localparam int TIMEOUT_W = 16;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5;

   // Input opcodes.
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_PACKET = 2'd1;
   localparam logic [1:0] OP_STEP   = 2'd2;

   // Result actions.
   localparam logic [1:0] ACT_NONE     = 2'd0;
   localparam logic [1:0] ACT_IDENTIFY = 2'd1;
   localparam logic [1:0] ACT_POLL     = 2'd2;
   localparam logic [1:0] ACT_PASS     = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] now_time;
      logic [7:0]  pkt_source;
      logic        pkt_is_info;
      logic        info_valid;
   } req_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [4:0]  dest_slot;
      logic        busy_res;
      logic [4:0]  found_count;
      logic [15:0] present_map;
      logic        last;
   } rsp_type;

   // One or two results handed from the core to the output stage.
   typedef struct packed {
      logic    valid;
      logic    two;
      rsp_type first;
      rsp_type second;
   } load_type;

endpackage

`default_nettype wire

// ===== sv/bsds_req_if.sv =====
// ----------------------------------------------------------------------------
// bsds_req_if
// Valid/ready channel that carries discovery events into the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bsds_req_if;
   logic             valid;
   logic             ready;
   bsds_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/bsds_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bsds_rsp_if
// Valid/ready channel that carries sweep results out of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bsds_rsp_if;
   logic             valid;
   logic             ready;
   bsds_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/bsds_core.sv =====
// ----------------------------------------------------------------------------
// bsds_core
// Input register, sweep state and the single-pass update that forms results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bus_slot_discovery_sweep_defines.svh"

module bsds_core #(
   parameter int SLOT_FIRST = 1,
   parameter int SLOT_LAST  = 15
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   bsds_req_if.sink                           req_bus,
   input  wire logic                          csr_wr_en,
   input  wire logic [bsds_pkg::TIMEOUT_W-1:0] csr_wr_data,
   input  wire logic                          load_free,
   output bsds_pkg::load_type                 load
);
   import bsds_pkg::*;

   // The slot counter must hold the first slot and one past the last slot.
   localparam int SLOT_MAX = (SLOT_FIRST > SLOT_LAST + 1) ? SLOT_FIRST : SLOT_LAST + 1;
   localparam int SLOT_W   = $clog2(SLOT_MAX + 1);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_PROBE = 2'd1;
   localparam logic [1:0] PH_WAIT  = 2'd2;

   logic                 in_valid_ff, in_valid_in;
   req_type              in_item_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [1:0]           phase_ff, phase_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [31:0]          deadline_ff, deadline_in;
   logic [15:0]          presence_ff, presence_in;
   logic [4:0]           found_ff, found_in;

   logic       fire;
   logic       two;
   logic [1:0] action;
   logic [7:0] slot_ext;
   logic [7:0] slot_next_ext;
   logic [31:0] elapsed;

   assign fire          = in_valid_ff && load_free;
   assign req_bus.ready = !reset && (!in_valid_ff || fire);
   assign in_valid_in   = (req_bus.valid && req_bus.ready) || (in_valid_ff && !fire);

   assign slot_ext      = 8'(slot_ff);
   assign slot_next_ext = slot_ext + 8'd1;
   assign elapsed       = in_item_ff.now_time - deadline_ff;

   always_comb begin
      phase_in    = phase_ff;
      slot_in     = slot_ff;
      deadline_in = deadline_ff;
      presence_in = presence_ff;
      found_in    = found_ff;
      action      = ACT_NONE;
      two         = 1'b0;
      case (in_item_ff.opcode)
         OP_START: begin
            presence_in = '0;
            found_in    = '0;
            slot_in     = SLOT_W'(SLOT_FIRST);
            phase_in    = PH_PROBE;
         end
         OP_PACKET: begin
            if (phase_ff == PH_WAIT && in_item_ff.pkt_source == slot_ext &&
                in_item_ff.pkt_is_info) begin
               if (in_item_ff.info_valid) begin
                  if (slot_ext < 8'd16) begin
                     presence_in[slot_ext[3:0]] = 1'b1;
                  end
                  if (found_ff != 5'd31) begin
                     found_in = found_ff + 5'd1;
                  end
               end
               slot_in  = SLOT_W'(slot_next_ext);
               phase_in = (slot_next_ext > 8'(SLOT_LAST)) ? PH_IDLE : PH_PROBE;
            end else begin
               action = ACT_PASS;
            end
         end
         OP_STEP: begin
            if (phase_ff == PH_PROBE) begin
               if (slot_ext > 8'(SLOT_LAST)) begin
                  phase_in = PH_IDLE;
               end else begin
                  deadline_in = in_item_ff.now_time + 32'(timeout_ff);
                  phase_in    = PH_WAIT;
                  two         = 1'b1;
               end
            end else if (phase_ff == PH_WAIT) begin
               // Wrap-safe expiry: the deadline has passed when the signed
               // difference is not negative.
               if (!elapsed[31]) begin
                  if (slot_ext < 8'd16) begin
                     presence_in[slot_ext[3:0]] = 1'b0;
                  end
                  slot_in  = SLOT_W'(slot_next_ext);
                  phase_in = (slot_next_ext > 8'(SLOT_LAST)) ? PH_IDLE : PH_PROBE;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      load.valid              = fire;
      load.two                = two;
      load.first.action       = two ? ACT_IDENTIFY : action;
      load.first.dest_slot    = two ? slot_ext[4:0] : 5'd0;
      load.first.busy_res     = (phase_in != PH_IDLE);
      load.first.found_count  = found_in;
      load.first.present_map  = presence_in;
      load.first.last         = !two;
      load.second             = load.first;
      load.second.action      = ACT_POLL;
      load.second.last        = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         timeout_ff  <= TIMEOUT_RESET;
         phase_ff    <= PH_IDLE;
         slot_ff     <= '0;
         deadline_ff <= '0;
         presence_ff <= '0;
         found_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         if (fire) begin
            phase_ff    <= phase_in;
            slot_ff     <= slot_in;
            deadline_ff <= deadline_in;
            presence_ff <= presence_in;
            found_ff    <= found_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_item_ff <= req_bus.payload;
      end
   end

   `BSDS_ASSERT_NEXT(a_hold_item, clock, reset, in_valid_ff && !load_free,
      in_valid_ff && $stable(in_item_ff), "stalled input item was lost or changed")
   `BSDS_ASSERT_NEXT(a_start_clears, clock, reset, fire && in_item_ff.opcode == OP_START,
      phase_ff == PH_PROBE && found_ff == 5'd0 && presence_ff == 16'd0,
      "start did not clear the sweep")
   `BSDS_ASSERT_IMPL(a_wait_in_range, clock, reset, phase_ff == PH_WAIT,
      slot_ext <= 8'(SLOT_LAST), "waiting on a slot beyond the last slot")

endmodule

`default_nettype wire

// ===== sv/bsds_out.sv =====
// ----------------------------------------------------------------------------
// bsds_out
// Result register with one extra entry for the second result of a probe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bus_slot_discovery_sweep_defines.svh"

module bsds_out (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bsds_pkg::load_type load,
   output logic                    load_free,
   bsds_rsp_if.source              rsp_bus
);
   import bsds_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    second_valid_ff, second_valid_in;
   rsp_type out_ff;
   rsp_type second_ff;
   logic    xfer;

   assign xfer            = rsp_bus.valid && rsp_bus.ready;
   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.payload = out_ff;

   // A new pair may enter when no result is held, or when the current result leaves with nothing behind it.
   assign load_free = !out_valid_ff || (rsp_bus.ready && !second_valid_ff);

   always_comb begin
      out_valid_in    = out_valid_ff;
      second_valid_in = second_valid_ff;
      if (load.valid) begin
         out_valid_in    = 1'b1;
         second_valid_in = load.two;
      end else if (xfer) begin
         out_valid_in    = second_valid_ff;
         second_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff    <= 1'b0;
         second_valid_ff <= 1'b0;
      end else begin
         out_valid_ff    <= out_valid_in;
         second_valid_ff <= second_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load.valid) begin
         out_ff    <= load.first;
         second_ff <= load.second;
      end else if (xfer && second_valid_ff) begin
         out_ff <= second_ff;
      end
   end

   `BSDS_ASSERT_IMPL(a_second_behind_first, clock, reset, second_valid_ff, out_valid_ff,
      "second result pending without a shown result")
   `BSDS_ASSERT_IMPL(a_not_last_has_more, clock, reset, out_valid_ff && !out_ff.last,
      second_valid_ff, "result not marked last but nothing follows it")
   `BSDS_ASSERT_IMPL(a_load_when_free, clock, reset, load.valid, load_free,
      "result pair loaded while the output stage was full")

endmodule

`default_nettype wire

// ===== sv/bus_slot_discovery_sweep.sv =====
// ----------------------------------------------------------------------------
// bus_slot_discovery_sweep
// Path: input register, then result register, then the result port.
// Throughput: one input per cycle while results are taken; a probe step
// yields two results, sent in turn through the single result port.
// Reset (synchronous): sweep idle, slot, deadline, map and count zero,
// poll timeout 5; no results pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bus_slot_discovery_sweep #(
   parameter int SLOT_FIRST = 1,
   parameter int SLOT_LAST  = 15
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   bsds_req_if.sink                            req_bus,
   bsds_rsp_if.source                          rsp_bus,
   input  wire logic                           csr_wr_en,
   input  wire logic [bsds_pkg::TIMEOUT_W-1:0] csr_wr_data
);
   import bsds_pkg::*;

   load_type load;
   logic     load_free;

   bsds_core #(
      .SLOT_FIRST (SLOT_FIRST),
      .SLOT_LAST  (SLOT_LAST)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .load_free   (load_free),
      .load        (load)
   );

   bsds_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .load_free (load_free),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire
